>>> sv/chkv_pkg.sv
`timescale 1ns / 1ps
package chkv_pkg;
   // bucket is the low bits of the key, so this stays a power of two
   localparam int BUCKETS = 64;

   localparam logic [1:0] FUNC_SET    = 2'd0;
   localparam logic [1:0] FUNC_GET    = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_ABSENT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_NODE,
      ST_CHECK,
      ST_ACT,
      ST_POP,
      ST_RESULT
   } state_type;
endpackage

>>> sv/chained_hash_key_value_store.sv
`timescale 1ns / 1ps
// Channel  Direction  Payload
// req      in         tdata: func[1:0], key[32:2], name_ref, email_ref, class_ref (pad to 136)
// rsp      out        tdata: status[1:0], found_name_ref, found_email_ref, found_class_ref
//
// One item at a time: the item is taken, then the bucket head is read, then each chain
// node visited (at least one) is read and checked, then the table is updated and the
// result presented; the chain walk through the node memory sets the rate. After reset a
// clearing pass writes every bucket head and the free stack, overlapped; no item is
// accepted meanwhile. A stalled result holds in the output register; the next item is
// taken once it has been accepted.
module chained_hash_key_value_store
   import chkv_pkg::*;
#(
   parameter int POOL_SIZE = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // func, key, name_ref, email_ref, class_ref, zeros
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata   // status, found_name_ref, found_email_ref, found_class_ref, zeros
);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int CW = NW + 1;
   localparam int SW = (BW > NW) ? BW : NW;
   localparam logic [CW-1:0] POOL_C = CW'(POOL_SIZE);

   // memories
   logic [NW:0]   head_mem [BUCKETS];   // valid, index
   logic [30:0]   key_mem  [POOL_SIZE];
   logic [NW:0]   next_mem [POOL_SIZE];
   logic [95:0]   pay_mem  [POOL_SIZE];
   logic [NW-1:0] free_mem [POOL_SIZE];

   state_type state_ff, state_in;

   logic [1:0]    func_ff;
   logic [30:0]   key_ff;
   logic [95:0]   data_ff;
   logic [CW-1:0] count_ff;
   logic [SW:0]   clr_ff;
   logic [CW-1:0] steps_ff;
   logic          found_ff, has_prev_ff;
   logic [NW-1:0] cur_ff, prev_ff;
   logic          cur_v_ff;

   logic [NW:0]   head_rd, next_rd;
   logic [30:0]   key_rd;
   logic [95:0]   pay_rd;
   logic [NW-1:0] free_rd;

   logic          rsp_v_ff;
   logic [1:0]    status_ff;
   logic [95:0]   out_ff;

   logic [BW-1:0] bucket;
   assign bucket = key_ff[BW-1:0];   // key modulo BUCKETS

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == (SW+1)'(((BUCKETS > POOL_SIZE) ? BUCKETS : POOL_SIZE) - 1))
                       state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid && !rsp_v_ff) state_in = ST_HEAD;
         ST_HEAD:   state_in = ST_NODE;
         ST_NODE:   state_in = ST_CHECK;
         ST_CHECK:  begin
            if (!cur_v_ff || steps_ff == POOL_C) state_in = ST_ACT;
            else if (key_rd == key_ff) state_in = ST_ACT;
            else state_in = ST_NODE;
         end
         ST_ACT:    state_in = (func_ff == FUNC_SET && !found_ff && count_ff != '0)
                                 ? ST_POP : ST_RESULT;
         ST_POP:    state_in = ST_RESULT;
         ST_RESULT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         count_ff <= POOL_C;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff < (SW+1)'(BUCKETS)) head_mem[clr_ff[BW-1:0]] <= '0;
               if (clr_ff < (SW+1)'(POOL_SIZE))
                  free_mem[clr_ff[NW-1:0]] <= NW'(POOL_SIZE - 1) - clr_ff[NW-1:0];
            end
            ST_IDLE: if (req_tvalid && !rsp_v_ff) begin
               func_ff <= req_tdata[1:0];
               key_ff  <= req_tdata[32:2];
               data_ff <= req_tdata[128:33];
            end
            ST_HEAD: begin
               head_rd     <= head_mem[bucket];
               found_ff    <= 1'b0;
               has_prev_ff <= 1'b0;
               steps_ff    <= '0;
            end
            ST_NODE: begin
               // head_rd on first visit, next_rd afterwards
               cur_v_ff <= (steps_ff == '0) ? head_rd[NW] : next_rd[NW];
               cur_ff   <= (steps_ff == '0) ? head_rd[NW-1:0] : next_rd[NW-1:0];
               if (steps_ff != '0) begin
                  prev_ff     <= cur_ff;
                  has_prev_ff <= 1'b1;
               end
               key_rd  <= key_mem[(steps_ff == '0) ? head_rd[NW-1:0] : next_rd[NW-1:0]];
               next_rd <= next_mem[(steps_ff == '0) ? head_rd[NW-1:0] : next_rd[NW-1:0]];
               pay_rd  <= pay_mem[(steps_ff == '0) ? head_rd[NW-1:0] : next_rd[NW-1:0]];
            end
            ST_CHECK: begin
               steps_ff <= steps_ff + 1'b1;
               if (cur_v_ff && steps_ff != POOL_C && key_rd == key_ff) found_ff <= 1'b1;
               free_rd <= free_mem[NW'(count_ff - 1'b1)];
            end
            ST_ACT: begin
               status_ff <= STATUS_ABSENT;
               out_ff    <= '0;
               unique case (func_ff)
                  FUNC_SET: begin
                     if (found_ff) begin
                        pay_mem[cur_ff] <= data_ff;
                        status_ff <= STATUS_OK;
                     end else if (count_ff == '0) status_ff <= STATUS_FULL;
                  end
                  FUNC_GET: if (found_ff) begin
                     status_ff <= STATUS_OK;
                     out_ff    <= pay_rd;
                  end
                  FUNC_REMOVE: if (found_ff) begin
                     status_ff <= STATUS_OK;
                     if (has_prev_ff) next_mem[prev_ff] <= next_rd;
                     else head_mem[bucket] <= next_rd;
                     if (count_ff < POOL_C) begin
                        free_mem[count_ff[NW-1:0]] <= cur_ff;
                        count_ff <= count_ff + 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            ST_POP: begin
               count_ff <= count_ff - 1'b1;
               key_mem[free_rd]  <= key_ff;
               next_mem[free_rd] <= head_rd;
               pay_mem[free_rd]  <= data_ff;
               head_mem[bucket]  <= {1'b1, free_rd};
               status_ff <= STATUS_OK;
            end
            ST_RESULT: rsp_v_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {6'd0, out_ff[95:64], out_ff[63:32], out_ff[31:0], status_ff};
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import chkv_pkg::*;

   localparam int NB = BUCKETS;
   localparam int NP = 128;
   localparam int N_RANDOM = 480;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;   // func[1:0], key[32:2], name[64:33], email[96:65], class[128:97]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;   // status[1:0], name[33:2], email[65:34], class[97:66]

   chained_hash_key_value_store #(.POOL_SIZE(NP)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   typedef struct packed {
      logic [1:0]  func;
      logic [30:0] key;
      logic [31:0] name_ref;
      logic [31:0] email_ref;
      logic [31:0] class_ref;
   } op_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] name_ref;
      logic [31:0] email_ref;
      logic [31:0] class_ref;
   } reply_t;

   // shadow of the table
   logic [6:0]  head_idx [NB];
   logic        head_ok  [NB];
   logic [30:0] nkey     [NP];
   logic [6:0]  nnext    [NP];
   logic        nnext_ok [NP];
   logic [95:0] npay     [NP];
   logic [6:0]  free_stk [NP];
   int          free_cnt;

   reply_t expected_replies[$];
   int     errors = 0;
   bit     quiet = 0;
   logic [30:0] live_keys[$];

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic reply_t table_access(op_t op);
      reply_t r;
      int b, cur, prv, steps, nd;
      bit ok, hit, has_prv;
      r = '0;
      r.status = STATUS_ABSENT;
      b = op.key % NB;
      ok = head_ok[b];
      cur = head_idx[b];
      hit = 0; has_prv = 0; prv = 0; nd = 0;
      for (steps = 0; ok && steps < NP && !hit; steps++) begin
         if (nkey[cur] == op.key) begin
            hit = 1; nd = cur;
         end else begin
            prv = cur; has_prv = 1;
            ok = nnext_ok[cur];
            cur = nnext[cur];
         end
      end
      case (op.func)
         FUNC_SET: begin
            if (!hit) begin
               if (free_cnt == 0) r.status = STATUS_FULL;
               else begin
                  free_cnt--;
                  nd = free_stk[free_cnt];
                  nkey[nd] = op.key;
                  nnext[nd] = head_idx[b];
                  nnext_ok[nd] = head_ok[b];
                  head_idx[b] = 7'(nd);
                  head_ok[b] = 1;
                  hit = 1;
               end
            end
            if (hit) begin
               npay[nd] = {op.class_ref, op.email_ref, op.name_ref};
               r.status = STATUS_OK;
            end
         end
         FUNC_GET: begin
            if (hit) begin
               r.status = STATUS_OK;
               {r.class_ref, r.email_ref, r.name_ref} = npay[nd];
            end
         end
         FUNC_REMOVE: begin
            if (hit) begin
               if (has_prv) begin
                  nnext[prv] = nnext[nd];
                  nnext_ok[prv] = nnext_ok[nd];
               end else begin
                  head_idx[b] = nnext[nd];
                  head_ok[b] = nnext_ok[nd];
               end
               if (free_cnt < NP) begin
                  free_stk[free_cnt] = 7'(nd);
                  free_cnt++;
               end
               r.status = STATUS_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(op_t op);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, op.class_ref, op.email_ref, op.name_ref, op.key, op.func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_replies.push_back(table_access(op));
      @(negedge clock);
   endtask

   // receiver with random stall bursts
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            stall = $urandom_range(1, 6);
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      reply_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[65:34], rsp_tdata[97:66]};
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply %h", $time, got);
            errors++;
         end else begin
            want = expected_replies.pop_front();
            if (got.status != want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.name_ref != want.name_ref) begin
               $display("%0t: name_ref expected %h actual %h", $time, want.name_ref,
                        got.name_ref);
               errors++;
            end
            if (got.email_ref != want.email_ref) begin
               $display("%0t: email_ref expected %h actual %h", $time, want.email_ref,
                        got.email_ref);
               errors++;
            end
            if (got.class_ref != want.class_ref) begin
               $display("%0t: class_ref expected %h actual %h", $time, want.class_ref,
                        got.class_ref);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] rnd_ref();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] rnd_key();
      logic [30:0] k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: if (live_keys.size() > 0)
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else k = 31'($urandom_range(0, 300));
         4, 5: k = 31'($urandom_range(0, 7) * NB + $urandom_range(0, 2)); // long chains
         6: k = 31'(32'h7FFF_FFFF - $urandom_range(0, 3));
         7: k = 31'($urandom);
         default: k = 31'($urandom_range(0, 400));
      endcase
      return k;
   endfunction

   // directed: func, key, refs, status expected at a glance (or 3 = predictor only)
   typedef struct {
      logic [1:0]  func;
      logic [30:0] key;
      logic [31:0] nm, em, cl;
      int          want;
   } row_t;

   row_t dir_tab[] = '{
      '{FUNC_GET,    31'd0,          32'h0, 32'h0, 32'h0, STATUS_ABSENT},
      '{FUNC_REMOVE, 31'd5,          32'h0, 32'h0, 32'h0, STATUS_ABSENT},
      '{FUNC_SET,    31'd0,          32'h0, 32'h0, 32'h0, STATUS_OK},
      '{FUNC_SET,    31'h7FFFFFFF,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, STATUS_OK},
      '{FUNC_GET,    31'h7FFFFFFF,   32'h0, 32'h0, 32'h0, 3},
      '{FUNC_GET,    31'd0,          32'h0, 32'h0, 32'h0, 3},
      '{FUNC_SET,    31'd64,         32'h11, 32'h22, 32'h33, STATUS_OK},
      '{FUNC_SET,    31'd128,        32'h44, 32'h55, 32'h66, STATUS_OK},
      '{FUNC_GET,    31'd64,         32'h0, 32'h0, 32'h0, 3},
      '{FUNC_SET,    31'd64,         32'hA5A5A5A5, 32'h5A5A5A5A, 32'h1, STATUS_OK},
      '{FUNC_GET,    31'd64,         32'h0, 32'h0, 32'h0, 3},
      '{FUNC_REMOVE, 31'd64,         32'h0, 32'h0, 32'h0, STATUS_OK},
      '{FUNC_GET,    31'd64,         32'h0, 32'h0, 32'h0, STATUS_ABSENT},
      '{FUNC_GET,    31'd128,        32'h0, 32'h0, 32'h0, 3},
      '{FUNC_REMOVE, 31'd0,          32'h0, 32'h0, 32'h0, STATUS_OK},
      '{FUNC_REMOVE, 31'd128,        32'h0, 32'h0, 32'h0, STATUS_OK},
      '{FUNC_REMOVE, 31'd128,        32'h0, 32'h0, 32'h0, STATUS_ABSENT},
      '{2'd3,        31'h7FFFFFFF,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, STATUS_ABSENT},
      '{FUNC_GET,    31'h7FFFFFFF,   32'h0, 32'h0, 32'h0, 3}
   };

   initial begin
      op_t op;
      int i, n, wait_cnt;
      for (i = 0; i < NB; i++) begin
         head_ok[i] = 0; head_idx[i] = 0;
      end
      for (i = 0; i < NP; i++) begin
         nkey[i] = 0; nnext[i] = 0; nnext_ok[i] = 0; npay[i] = 0;
         free_stk[i] = 7'(NP - 1 - i);
      end
      free_cnt = NP;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         op = '{dir_tab[i].func, dir_tab[i].key, dir_tab[i].nm, dir_tab[i].em, dir_tab[i].cl};
         send_item(op);
         if (dir_tab[i].want != 3 &&
             expected_replies[$].status != dir_tab[i].want[1:0]) begin
            $display("%0t: row %0d status expected %0d actual %0d", $time, i,
                     dir_tab[i].want, expected_replies[$].status);
            errors++;
         end
      end

      // fill the pool to exhaustion with distinct keys, then probe full-pool cases
      n = 0;
      while (free_cnt > 0) begin
         op = '{FUNC_SET, 31'(1000 + n * 7), rnd_ref(), rnd_ref(), rnd_ref()};
         live_keys.push_back(op.key);
         send_item(op);
         n++;
      end
      send_item('{FUNC_SET, 31'd999999, 32'h1, 32'h2, 32'h3});
      send_item('{FUNC_SET, live_keys[5], 32'hDEAD, 32'hBEEF, 32'hCAFE});
      send_item('{FUNC_GET, live_keys[5], 32'h0, 32'h0, 32'h0});
      // drain most of the pool again
      for (i = 0; i < 120; i++) begin
         send_item('{FUNC_REMOVE, live_keys[0], rnd_ref(), rnd_ref(), rnd_ref()});
         void'(live_keys.pop_front());
      end

      for (i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - 120) quiet = 1;
         op.key = rnd_key();
         op.name_ref = rnd_ref();
         op.email_ref = rnd_ref();
         op.class_ref = rnd_ref();
         case ($urandom_range(0, 19))
            0: op.func = 2'd3;
            1, 2, 3, 4, 5, 6, 7: op.func = FUNC_SET;
            8, 9, 10, 11, 12, 13, 14: op.func = FUNC_GET;
            default: op.func = FUNC_REMOVE;
         endcase
         if (op.func == FUNC_SET) live_keys.push_back(op.key);
         if (live_keys.size() > 200) void'(live_keys.pop_front());
         send_item(op);
      end
      req_tvalid <= 1'b0;

      wait_cnt = 0;
      while (expected_replies.size() > 0 && wait_cnt < 100000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_replies.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

>>> files.f
sv/chkv_pkg.sv
sv/chained_hash_key_value_store.sv
dv/tb_top.sv
